/* design/vta_pkg.sv */
// ----------------------------------------------------------------------------
// Vector to view angles: shared definitions
// Widths, fixed-point constants, the arctangent table and the stage record
// of the two-pass CORDIC pipeline.
// ----------------------------------------------------------------------------
package vta_pkg;

    localparam int COORD_WIDTH  = 20;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NUM_STEPS    = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    localparam int COORD_SHIFT  = 16;
    localparam int DATA_WIDTH   = COORD_WIDTH + COORD_SHIFT + 5;
    localparam int GAIN_WIDTH   = 21;
    localparam int GAIN_SHIFT   = 4;
    localparam int PROD_WIDTH   = COORD_WIDTH + GAIN_WIDTH + 1;

    localparam int ANGLE_WIDTH  = 27;
    localparam int ROUND_SHIFT  = 8;
    localparam int ROUND_HALF   = 128;
    localparam int RND_WIDTH    = ANGLE_WIDTH - ROUND_SHIFT;
    localparam int OUT_WIDTH    = 17;

    localparam logic [GAIN_WIDTH-1:0] GAIN_Q20 = 21'd1726753;
    localparam int FULL_TURN_Q8 = 92160;
    localparam int DEG90_Q8     = 23040;
    localparam int DEG270_Q8    = 69120;
    localparam int DEG180_Q16   = 11796480;

    localparam int ATAN_TABLE [ATAN_ENTRIES] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  x;
        logic signed [DATA_WIDTH-1:0]  y;
        logic signed [DATA_WIDTH-1:0]  zk;
        logic signed [ANGLE_WIDTH-1:0] ang;
        logic signed [ANGLE_WIDTH-1:0] yaw;
        logic                          zero_h;
        logic                          z_pos;
    } cordic_stage_t;

endpackage

/* design/vector_to_view_angles.sv */
// An accepted vector passes through every stage register and then the output register.
// Throughput: one vector per cycle unless stalled; one micro-rotation per stage after 0.
// Empty stages close up while the output is stalled, so input is taken until all are full.
// Reset clears only the valid bits of the stages and of the output register.
// ----------------------------------------------------------------------------
// Vector to view angles
// Converts a 3-D direction vector into yaw and pitch in degrees with eight
// fraction bits, using two unrolled CORDIC vectoring passes.
// ----------------------------------------------------------------------------
module vector_to_view_angles (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   vec_valid,
    output logic                                   vec_stall,
    input  logic signed [vta_pkg::COORD_WIDTH-1:0] x_delta,
    input  logic signed [vta_pkg::COORD_WIDTH-1:0] y_delta,
    input  logic signed [vta_pkg::COORD_WIDTH-1:0] z_delta,
    output logic                                   ang_valid,
    input  logic                                   ang_stall,
    output logic [vta_pkg::OUT_WIDTH-1:0]          yaw_angle,
    output logic [vta_pkg::OUT_WIDTH-1:0]          pitch_angle
);

    import vta_pkg::*;

    localparam int LAST = 2 * NUM_STEPS;

    cordic_stage_t                 stage_reg  [0:LAST];
    cordic_stage_t                 stage_next [0:LAST];
    logic                          valid_reg  [0:LAST];
    logic                          ready      [0:LAST+1];

    logic                          ang_valid_reg;
    logic [OUT_WIDTH-1:0]          yaw_angle_reg;
    logic [OUT_WIDTH-1:0]          pitch_angle_reg;
    logic [OUT_WIDTH-1:0]          yaw_angle_next;
    logic [OUT_WIDTH-1:0]          pitch_angle_next;

    logic signed [DATA_WIDTH-1:0]  x_ext;
    logic signed [DATA_WIDTH-1:0]  y_ext;
    logic signed [DATA_WIDTH-1:0]  x_abs;
    logic signed [DATA_WIDTH-1:0]  y_abs;
    logic signed [PROD_WIDTH-1:0]  z_prod;

    function automatic cordic_stage_t cordic_step(input cordic_stage_t s, input int i);
        cordic_stage_t                r;
        logic signed [DATA_WIDTH-1:0] xs;
        logic signed [DATA_WIDTH-1:0] ys;
        r  = s;
        xs = $signed(s.x) >>> i;
        ys = $signed(s.y) >>> i;
        if (!s.y[DATA_WIDTH-1])
        begin
            r.x   = $signed(s.x) + ys;
            r.y   = $signed(s.y) - xs;
            r.ang = $signed(s.ang) + ANGLE_WIDTH'(ATAN_TABLE[i]);
        end
        else
        begin
            r.x   = $signed(s.x) - ys;
            r.y   = $signed(s.y) + xs;
            r.ang = $signed(s.ang) - ANGLE_WIDTH'(ATAN_TABLE[i]);
        end
        return r;
    endfunction

    function automatic logic [OUT_WIDTH-1:0] wrap_angle(input logic signed [ANGLE_WIDTH-1:0] a);
        logic signed [RND_WIDTH-1:0] r;
        r = RND_WIDTH'((a + ROUND_HALF) >>> ROUND_SHIFT);
        if (r < 0)
        begin
            r = r + RND_WIDTH'(FULL_TURN_Q8);
        end
        else if (r >= RND_WIDTH'(FULL_TURN_Q8))
        begin
            r = r - RND_WIDTH'(FULL_TURN_Q8);
        end
        return OUT_WIDTH'(r);
    endfunction

    // The left half plane is folded over by negating both coordinates.
    always_comb
    begin
        x_ext  = DATA_WIDTH'(x_delta);
        y_ext  = DATA_WIDTH'(y_delta);
        x_abs  = x_delta[COORD_WIDTH-1] ? -x_ext : x_ext;
        y_abs  = x_delta[COORD_WIDTH-1] ? -y_ext : y_ext;
        z_prod = PROD_WIDTH'(z_delta) * PROD_WIDTH'($signed({1'b0, GAIN_Q20}));

        stage_next[0].x      = x_abs <<< COORD_SHIFT;
        stage_next[0].y      = y_abs <<< COORD_SHIFT;
        stage_next[0].zk     = DATA_WIDTH'(z_prod >>> GAIN_SHIFT);
        stage_next[0].ang    = x_delta[COORD_WIDTH-1] ? ANGLE_WIDTH'(DEG180_Q16) : '0;
        stage_next[0].yaw    = '0;
        stage_next[0].zero_h = (x_delta == '0) && (y_delta == '0);
        stage_next[0].z_pos  = !z_delta[COORD_WIDTH-1] && (z_delta != '0);
    end

    genvar j;
    generate
        for (j = 0; j < LAST; j++)
        begin : g_step
            if (j == NUM_STEPS)
            begin : g_pitch_start
                // The second pass starts from the horizontal length and the scaled height.
                always_comb
                begin
                    stage_next[j+1] = cordic_step(
                        '{x:      stage_reg[j].x,
                          y:      stage_reg[j].zk,
                          zk:     stage_reg[j].zk,
                          ang:    '0,
                          yaw:    stage_reg[j].ang,
                          zero_h: stage_reg[j].zero_h,
                          z_pos:  stage_reg[j].z_pos},
                        0);
                end
            end
            else
            begin : g_plain
                always_comb
                begin
                    stage_next[j+1] = cordic_step(stage_reg[j],
                                                  (j < NUM_STEPS) ? j : j - NUM_STEPS);
                end
            end
        end

        for (j = 0; j <= LAST; j++)
        begin : g_stage
            assign ready[j] = !valid_reg[j] || ready[j+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j] <= 1'b0;
                end
                else if (ready[j])
                begin
                    valid_reg[j] <= (j == 0) ? vec_valid : valid_reg[(j == 0) ? 0 : j-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ready[j])
                begin
                    stage_reg[j] <= stage_next[j];
                end
            end
        end
    endgenerate

    assign ready[LAST+1] = !ang_valid_reg || !ang_stall;

    always_comb
    begin
        if (stage_reg[LAST].zero_h)
        begin
            yaw_angle_next   = '0;
            pitch_angle_next = stage_reg[LAST].z_pos ? OUT_WIDTH'(DEG90_Q8)
                                                     : OUT_WIDTH'(DEG270_Q8);
        end
        else
        begin
            yaw_angle_next   = wrap_angle(stage_reg[LAST].yaw);
            pitch_angle_next = wrap_angle(stage_reg[LAST].ang);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_valid_reg <= 1'b0;
        end
        else if (ready[LAST+1])
        begin
            ang_valid_reg <= valid_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[LAST+1])
        begin
            yaw_angle_reg   <= yaw_angle_next;
            pitch_angle_reg <= pitch_angle_next;
        end
    end

    assign vec_stall   = !ready[0];
    assign ang_valid   = ang_valid_reg;
    assign yaw_angle   = yaw_angle_reg;
    assign pitch_angle = pitch_angle_reg;

endmodule
